@@ src/aabb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package aabb_pkg;

    localparam int FIELD_WIDTH  = 32;
    localparam int COORD_WIDTH  = 32;
    localparam int FRAC_BITS    = 16;
    localparam int OPCODE_WIDTH = 3;
    localparam int AXIS_WIDTH   = 2;
    localparam int NUM_AXES     = 3;

    typedef enum logic [OPCODE_WIDTH-1:0] {
        OP_RESET     = 3'd0,
        OP_ADD_POINT = 3'd1,
        OP_MERGE_BOX = 3'd2,
        OP_TRANSFORM = 3'd3,
        OP_OVERLAP   = 3'd4
    } t_opcode;

    // axis code that selects no output axis
    localparam logic [AXIS_WIDTH-1:0] AXIS_NONE = 2'd3;

    typedef struct packed {
        logic    accept;
        logic    en_s1;
        logic    en_s2;
        t_opcode op;
    } t_lane_ctl;

endpackage

`default_nettype wire

@@ src/aabb_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

module aabb_lane #(
    parameter int CW = aabb_pkg::COORD_WIDTH,
    parameter int FB = aabb_pkg::FRAC_BITS
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire aabb_pkg::t_lane_ctl                     i_ctl,
    input  wire logic signed [aabb_pkg::FIELD_WIDTH-1:0] i_lo,
    input  wire logic signed [aabb_pkg::FIELD_WIDTH-1:0] i_hi,
    output logic signed [CW-1:0]                         o_next_min,
    output logic signed [CW-1:0]                         o_next_max,
    output logic                                         o_overlap,
    output logic signed [CW-1:0]                         o_low,
    output logic signed [CW-1:0]                         o_high,
    output logic                                         o_sat
);

    localparam int FW = aabb_pkg::FIELD_WIDTH;
    localparam int XW = (CW > FW) ? CW : FW;
    localparam int PW = FW + CW;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    function automatic logic signed [CW-1:0] clamp_in(input logic signed [XW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > XW'(CMAX)) begin
            r = CMAX;
        end else if (v < XW'(CMIN)) begin
            r = CMIN;
        end else begin
            r = CW'(v);
        end
        return r;
    endfunction

    logic signed [CW-1:0] r_min, r_max;
    logic signed [CW-1:0] n_min, n_max;
    logic signed [CW-1:0] lo_c, hi_c;

    assign lo_c = clamp_in(XW'(i_lo));
    assign hi_c = clamp_in(XW'(i_hi));

    assign o_overlap = (r_min <= hi_c) && (lo_c <= r_max);

    always_comb begin
        n_min = r_min;
        n_max = r_max;
        case (i_ctl.op)
            aabb_pkg::OP_RESET: begin
                n_min = CMAX;
                n_max = CMIN;
            end
            aabb_pkg::OP_ADD_POINT: begin
                if (lo_c < r_min) n_min = lo_c;
                if (lo_c > r_max) n_max = lo_c;
            end
            aabb_pkg::OP_MERGE_BOX: begin
                if (lo_c < r_min) n_min = lo_c;
                if (hi_c > r_max) n_max = hi_c;
            end
            default: begin
            end
        endcase
    end

    assign o_next_min = n_min;
    assign o_next_max = n_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= CMAX;
            r_max <= CMIN;
        end else if (i_ctl.accept) begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    // stage 1: exact products of the coefficient with both corners
    logic signed [PW-1:0] mul_c, mul_mn, mul_mx;
    logic signed [PW-1:0] r_prod_min, r_prod_max;

    assign mul_c  = PW'(i_lo);
    assign mul_mn = PW'(r_min);
    assign mul_mx = PW'(r_max);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s1) begin
            r_prod_min <= mul_c * mul_mn;
            r_prod_max <= mul_c * mul_mx;
        end
    end

    // stage 2: floor shift, saturate, order the pair
    logic signed [PW-1:0] q_a, q_b;
    logic signed [CW-1:0] f_a, f_b;
    logic                 sat_a, sat_b;

    always_comb begin
        q_a   = r_prod_min >>> FB;
        q_b   = r_prod_max >>> FB;
        sat_a = (q_a > PW'(CMAX)) || (q_a < PW'(CMIN));
        sat_b = (q_b > PW'(CMAX)) || (q_b < PW'(CMIN));
        f_a   = (q_a > PW'(CMAX)) ? CMAX : ((q_a < PW'(CMIN)) ? CMIN : CW'(q_a));
        f_b   = (q_b > PW'(CMAX)) ? CMAX : ((q_b < PW'(CMIN)) ? CMIN : CW'(q_b));
    end

    logic signed [CW-1:0] r_low, r_high;
    logic                 r_sat;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s2) begin
            r_low  <= (f_a < f_b) ? f_a : f_b;
            r_high <= (f_a < f_b) ? f_b : f_a;
            r_sat  <= sat_a || sat_b;
        end
    end

    assign o_low  = r_low;
    assign o_high = r_high;
    assign o_sat  = r_sat;

endmodule

`default_nettype wire

@@ src/aabb_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none

module aabb_merge #(
    parameter int CW = aabb_pkg::COORD_WIDTH
) (
    input  wire logic signed [aabb_pkg::FIELD_WIDTH-1:0] i_trans,
    input  wire logic signed [CW-1:0]                    i_low  [aabb_pkg::NUM_AXES],
    input  wire logic signed [CW-1:0]                    i_high [aabb_pkg::NUM_AXES],
    output logic signed [CW-1:0]                         o_low,
    output logic signed [CW-1:0]                         o_high,
    output logic                                         o_sat
);

    localparam int FW = aabb_pkg::FIELD_WIDTH;
    localparam int XW = (CW > FW) ? CW : FW;
    localparam int SW = XW + 2;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    logic signed [SW-1:0] sum_lo, sum_hi;

    always_comb begin
        sum_lo = SW'(i_trans);
        sum_hi = SW'(i_trans);
        for (int k = 0; k < aabb_pkg::NUM_AXES; k++) begin
            sum_lo = sum_lo + SW'(i_low[k]);
            sum_hi = sum_hi + SW'(i_high[k]);
        end
    end

    always_comb begin
        o_low  = (sum_lo > SW'(CMAX)) ? CMAX : ((sum_lo < SW'(CMIN)) ? CMIN : CW'(sum_lo));
        o_high = (sum_hi > SW'(CMAX)) ? CMAX : ((sum_hi < SW'(CMIN)) ? CMIN : CW'(sum_hi));
        o_sat  = (sum_lo > SW'(CMAX)) || (sum_lo < SW'(CMIN))
              || (sum_hi > SW'(CMAX)) || (sum_hi < SW'(CMIN));
    end

endmodule

`default_nettype wire

@@ src/aabb_accumulate_transform_test_top.sv @@
// Pipeline: an accepted beat passes the stage 1 and stage 2 registers and then the output
// register (multiply, floor/saturate/order per lane, sum and clamp across lanes).
// Throughput: one beat per cycle while o_stall is low; box updates finish in the accept cycle.
// Reset: synchronous, active low; box becomes empty, pipeline valids clear.
`timescale 1ns / 1ps
`default_nettype none

module aabb_accumulate_transform_test_top #(
    parameter int COORD_WIDTH = aabb_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = aabb_pkg::FRAC_BITS
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_valid,
    output logic                                          o_stall,
    input  wire logic [aabb_pkg::OPCODE_WIDTH-1:0]        i_opcode,
    input  wire logic signed [aabb_pkg::FIELD_WIDTH-1:0]  i_lo_x,
    input  wire logic signed [aabb_pkg::FIELD_WIDTH-1:0]  i_lo_y,
    input  wire logic signed [aabb_pkg::FIELD_WIDTH-1:0]  i_lo_z,
    input  wire logic signed [aabb_pkg::FIELD_WIDTH-1:0]  i_hi_x,
    input  wire logic signed [aabb_pkg::FIELD_WIDTH-1:0]  i_hi_y,
    input  wire logic signed [aabb_pkg::FIELD_WIDTH-1:0]  i_hi_z,
    input  wire logic [aabb_pkg::AXIS_WIDTH-1:0]          i_axis,
    output logic                                          o_valid,
    input  wire logic                                     i_stall,
    output logic signed [aabb_pkg::FIELD_WIDTH-1:0]       o_box_min_x,
    output logic signed [aabb_pkg::FIELD_WIDTH-1:0]       o_box_min_y,
    output logic signed [aabb_pkg::FIELD_WIDTH-1:0]       o_box_min_z,
    output logic signed [aabb_pkg::FIELD_WIDTH-1:0]       o_box_max_x,
    output logic signed [aabb_pkg::FIELD_WIDTH-1:0]       o_box_max_y,
    output logic signed [aabb_pkg::FIELD_WIDTH-1:0]       o_box_max_z,
    output logic                                          o_overlap,
    output logic signed [aabb_pkg::FIELD_WIDTH-1:0]       o_axis_low,
    output logic signed [aabb_pkg::FIELD_WIDTH-1:0]       o_axis_high,
    output logic                                          o_saturated
);

    localparam int FW = aabb_pkg::FIELD_WIDTH;
    localparam int NA = aabb_pkg::NUM_AXES;
    localparam int CW = COORD_WIDTH;

    // stage advance: each stage moves when empty or when the next one moves
    logic en_out, en2, en1, accept;
    logic r_v1, r_v2, r_out_valid;

    assign en_out  = !r_out_valid || !i_stall;
    assign en2     = !r_v2 || en_out;
    assign en1     = !r_v1 || en2;
    assign accept  = i_valid && en1;
    assign o_stall = !en1;
    assign o_valid = r_out_valid;

    aabb_pkg::t_opcode   op_in;
    aabb_pkg::t_lane_ctl lane_ctl;

    assign op_in           = aabb_pkg::t_opcode'(i_opcode);
    assign lane_ctl.accept = accept;
    assign lane_ctl.en_s1  = en1;
    assign lane_ctl.en_s2  = en2;
    assign lane_ctl.op     = op_in;

    logic signed [FW-1:0] w_lo [NA];
    logic signed [FW-1:0] w_hi [NA];
    logic signed [CW-1:0] w_next_min [NA];
    logic signed [CW-1:0] w_next_max [NA];
    logic signed [CW-1:0] w_low  [NA];
    logic signed [CW-1:0] w_high [NA];
    logic [NA-1:0]        w_ovl;
    logic [NA-1:0]        w_sat;

    assign w_lo[0] = i_lo_x;
    assign w_lo[1] = i_lo_y;
    assign w_lo[2] = i_lo_z;
    assign w_hi[0] = i_hi_x;
    assign w_hi[1] = i_hi_y;
    assign w_hi[2] = i_hi_z;

    for (genvar g = 0; g < NA; g++) begin : g_lane
        aabb_lane #(
            .CW(COORD_WIDTH),
            .FB(FRAC_BITS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (lane_ctl),
            .i_lo       (w_lo[g]),
            .i_hi       (w_hi[g]),
            .o_next_min (w_next_min[g]),
            .o_next_max (w_next_max[g]),
            .o_overlap  (w_ovl[g]),
            .o_low      (w_low[g]),
            .o_high     (w_high[g]),
            .o_sat      (w_sat[g])
        );
    end

    // stage 1
    aabb_pkg::t_opcode                  r_s1_op;
    logic [aabb_pkg::AXIS_WIDTH-1:0]    r_s1_axis;
    logic signed [FW-1:0]               r_s1_trans;
    logic signed [CW-1:0]               r_s1_min [NA];
    logic signed [CW-1:0]               r_s1_max [NA];
    logic                               r_s1_ovl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_op    <= op_in;
            r_s1_axis  <= i_axis;
            r_s1_trans <= i_hi_x;
            r_s1_min   <= w_next_min;
            r_s1_max   <= w_next_max;
            r_s1_ovl   <= (op_in == aabb_pkg::OP_OVERLAP) && (&w_ovl);
        end
    end

    // stage 2
    aabb_pkg::t_opcode                  r_s2_op;
    logic [aabb_pkg::AXIS_WIDTH-1:0]    r_s2_axis;
    logic signed [FW-1:0]               r_s2_trans;
    logic signed [CW-1:0]               r_s2_min [NA];
    logic signed [CW-1:0]               r_s2_max [NA];
    logic                               r_s2_ovl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_op    <= r_s1_op;
            r_s2_axis  <= r_s1_axis;
            r_s2_trans <= r_s1_trans;
            r_s2_min   <= r_s1_min;
            r_s2_max   <= r_s1_max;
            r_s2_ovl   <= r_s1_ovl;
        end
    end

    // merge across lanes
    logic signed [CW-1:0] m_low, m_high;
    logic                 m_sat;
    logic                 xform;

    aabb_merge #(
        .CW(COORD_WIDTH)
    ) u_merge (
        .i_trans (r_s2_trans),
        .i_low   (w_low),
        .i_high  (w_high),
        .o_low   (m_low),
        .o_high  (m_high),
        .o_sat   (m_sat)
    );

    assign xform = (r_s2_op == aabb_pkg::OP_TRANSFORM) && (r_s2_axis != aabb_pkg::AXIS_NONE);

    // output register
    logic signed [FW-1:0] r_out_min [NA];
    logic signed [FW-1:0] r_out_max [NA];
    logic                 r_out_ovl;
    logic signed [FW-1:0] r_out_low, r_out_high;
    logic                 r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            for (int k = 0; k < NA; k++) begin
                r_out_min[k] <= FW'(r_s2_min[k]);
                r_out_max[k] <= FW'(r_s2_max[k]);
            end
            r_out_ovl  <= r_s2_ovl;
            r_out_low  <= xform ? FW'(m_low) : '0;
            r_out_high <= xform ? FW'(m_high) : '0;
            r_out_sat  <= xform && (m_sat || (|w_sat));
        end
    end

    assign o_box_min_x = r_out_min[0];
    assign o_box_min_y = r_out_min[1];
    assign o_box_min_z = r_out_min[2];
    assign o_box_max_x = r_out_max[0];
    assign o_box_max_y = r_out_max[1];
    assign o_box_max_z = r_out_max[2];
    assign o_overlap   = r_out_ovl;
    assign o_axis_low  = r_out_low;
    assign o_axis_high = r_out_high;
    assign o_saturated = r_out_sat;

`ifndef ASSERT_OFF
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_v1)
        else $error("accepted beat did not enter stage 1");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_v1 && !r_v2 && !r_out_valid) |-> !o_stall)
        else $error("stall raised with empty pipeline");

    a_s2_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !en_out) |=> r_v2)
        else $error("stage 2 beat lost while output blocked");

    a_overlap_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ovl) |-> (r_out_low == '0 && r_out_high == '0 && !r_out_sat))
        else $error("overlap result carries transform fields");
`endif

endmodule

`default_nettype wire

@@ dv/aabb_result_checker.sv @@
`timescale 1ns / 1ps

module aabb_result_checker
    import aabb_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [OPCODE_WIDTH-1:0]        i_opcode,
    input  logic signed [FIELD_WIDTH-1:0]  i_lo_x,
    input  logic signed [FIELD_WIDTH-1:0]  i_lo_y,
    input  logic signed [FIELD_WIDTH-1:0]  i_lo_z,
    input  logic signed [FIELD_WIDTH-1:0]  i_hi_x,
    input  logic signed [FIELD_WIDTH-1:0]  i_hi_y,
    input  logic signed [FIELD_WIDTH-1:0]  i_hi_z,
    input  logic [AXIS_WIDTH-1:0]          i_axis,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic signed [FIELD_WIDTH-1:0]  i_box_min_x,
    input  logic signed [FIELD_WIDTH-1:0]  i_box_min_y,
    input  logic signed [FIELD_WIDTH-1:0]  i_box_min_z,
    input  logic signed [FIELD_WIDTH-1:0]  i_box_max_x,
    input  logic signed [FIELD_WIDTH-1:0]  i_box_max_y,
    input  logic signed [FIELD_WIDTH-1:0]  i_box_max_z,
    input  logic                           i_overlap,
    input  logic signed [FIELD_WIDTH-1:0]  i_axis_low,
    input  logic signed [FIELD_WIDTH-1:0]  i_axis_high,
    input  logic                           i_saturated,
    output int                             o_mismatches,
    output int                             o_pending
);

    localparam int     MAX_REPORTS = 10;
    localparam longint COORD_HI    = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_LO    = -COORD_HI - 1;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] min_x;
        logic signed [FIELD_WIDTH-1:0] min_y;
        logic signed [FIELD_WIDTH-1:0] min_z;
        logic signed [FIELD_WIDTH-1:0] max_x;
        logic signed [FIELD_WIDTH-1:0] max_y;
        logic signed [FIELD_WIDTH-1:0] max_z;
        logic                          overlap;
        logic signed [FIELD_WIDTH-1:0] axis_low;
        logic signed [FIELD_WIDTH-1:0] axis_high;
        logic                          saturated;
    } t_box_result;

    longint      corner_lo [NUM_AXES];
    longint      corner_hi [NUM_AXES];
    t_box_result box_results [$];
    t_box_result want;
    t_box_result seen;
    int          mismatches = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = box_results.size();

    function automatic bit out_of_range(input longint v);
        return (v > COORD_HI) || (v < COORD_LO);
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_HI) return COORD_HI;
        if (v < COORD_LO) return COORD_LO;
        return v;
    endfunction

    function automatic void clear_box();
        for (int i = 0; i < NUM_AXES; i++) begin
            corner_lo[i] = COORD_HI;
            corner_hi[i] = COORD_LO;
        end
    endfunction

    // advances the stored box and returns what the block should report
    function automatic t_box_result predict_box(
        input logic [OPCODE_WIDTH-1:0] op,
        input longint lx, input longint ly, input longint lz,
        input longint hx, input longint hy, input longint hz,
        input logic [AXIS_WIDTH-1:0] ax
    );
        longint      lo [NUM_AXES];
        longint      hi [NUM_AXES];
        longint      a;
        longint      b;
        longint      sum_lo;
        longint      sum_hi;
        bit          sat;
        bit          hit;
        t_box_result r;
        lo[0] = lx; lo[1] = ly; lo[2] = lz;
        hi[0] = hx; hi[1] = hy; hi[2] = hz;
        sat    = 1'b0;
        hit    = 1'b0;
        sum_lo = 0;
        sum_hi = 0;
        case (op)
            OP_RESET: clear_box();
            OP_ADD_POINT, OP_MERGE_BOX: begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    a = clamp_coord(lo[i]);
                    b = (op == OP_ADD_POINT) ? a : clamp_coord(hi[i]);
                    if (a < corner_lo[i]) corner_lo[i] = a;
                    if (b > corner_hi[i]) corner_hi[i] = b;
                end
            end
            OP_TRANSFORM: begin
                if (ax != AXIS_NONE) begin
                    sum_lo = hi[0];
                    sum_hi = hi[0];
                    for (int i = 0; i < NUM_AXES; i++) begin
                        // exact product, floor shift, then clamp each term
                        a = (lo[i] * corner_lo[i]) >>> FRAC_BITS;
                        b = (lo[i] * corner_hi[i]) >>> FRAC_BITS;
                        sat = sat | out_of_range(a) | out_of_range(b);
                        a = clamp_coord(a);
                        b = clamp_coord(b);
                        if (a < b) begin
                            sum_lo += a;
                            sum_hi += b;
                        end else begin
                            sum_lo += b;
                            sum_hi += a;
                        end
                    end
                    sat    = sat | out_of_range(sum_lo) | out_of_range(sum_hi);
                    sum_lo = clamp_coord(sum_lo);
                    sum_hi = clamp_coord(sum_hi);
                end
            end
            OP_OVERLAP: begin
                hit = 1'b1;
                for (int i = 0; i < NUM_AXES; i++) begin
                    a = clamp_coord(lo[i]);
                    b = clamp_coord(hi[i]);
                    if (!(corner_lo[i] <= b && a <= corner_hi[i])) hit = 1'b0;
                end
            end
            default: ;
        endcase
        r.min_x     = FIELD_WIDTH'(corner_lo[0]);
        r.min_y     = FIELD_WIDTH'(corner_lo[1]);
        r.min_z     = FIELD_WIDTH'(corner_lo[2]);
        r.max_x     = FIELD_WIDTH'(corner_hi[0]);
        r.max_y     = FIELD_WIDTH'(corner_hi[1]);
        r.max_z     = FIELD_WIDTH'(corner_hi[2]);
        r.overlap   = hit;
        r.axis_low  = FIELD_WIDTH'(sum_lo);
        r.axis_high = FIELD_WIDTH'(sum_hi);
        r.saturated = sat;
        return r;
    endfunction

    task automatic show_result(input string label, input t_box_result r);
        $display("  %s min %h %h %h max %h %h %h ovl %b low %h high %h sat %b",
                 label, r.min_x, r.min_y, r.min_z, r.max_x, r.max_y, r.max_z,
                 r.overlap, r.axis_low, r.axis_high, r.saturated);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_box();
            box_results.delete();
        end else begin
            // result side first: an output beat never belongs to this edge's input
            if (i_out_valid && !i_out_stall) begin
                seen = {i_box_min_x, i_box_min_y, i_box_min_z,
                        i_box_max_x, i_box_max_y, i_box_max_z, i_overlap,
                        i_axis_low, i_axis_high, i_saturated};
                if (box_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected result beat at %0t", $time);
                        show_result("actual  ", seen);
                    end
                end else begin
                    want = box_results.pop_front();
                    if (seen !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("result mismatch at %0t", $time);
                            show_result("expected", want);
                            show_result("actual  ", seen);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                box_results.push_back(predict_box(i_opcode,
                    longint'(i_lo_x), longint'(i_lo_y), longint'(i_lo_z),
                    longint'(i_hi_x), longint'(i_hi_y), longint'(i_hi_z), i_axis));
            end
        end
    end

endmodule

@@ dv/aabb_accumulate_transform_test_top_tb.sv @@
`timescale 1ns / 1ps

module aabb_accumulate_transform_test_top_tb;

    import aabb_pkg::*;

    localparam int W            = FIELD_WIDTH;
    localparam int RANDOM_BEATS = 650;
    localparam int DRAIN_CYCLES = 10;
    localparam int TIMEOUT_NS   = 2_000_000;

    localparam logic signed [W-1:0] C_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] C_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE   = 1 << FRAC_BITS;

    localparam logic [OPCODE_WIDTH-1:0] OP_UNUSED_FIRST = OPCODE_WIDTH'(OP_OVERLAP + 1);
    localparam logic [OPCODE_WIDTH-1:0] OP_UNUSED_LAST  = '1;

    logic                    i_clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [OPCODE_WIDTH-1:0] opcode = '0;
    logic signed [W-1:0]     lo_x = '0;
    logic signed [W-1:0]     lo_y = '0;
    logic signed [W-1:0]     lo_z = '0;
    logic signed [W-1:0]     hi_x = '0;
    logic signed [W-1:0]     hi_y = '0;
    logic signed [W-1:0]     hi_z = '0;
    logic [AXIS_WIDTH-1:0]   axis = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [W-1:0]     box_min_x, box_min_y, box_min_z;
    logic signed [W-1:0]     box_max_x, box_max_y, box_max_z;
    logic                    overlap;
    logic signed [W-1:0]     axis_low, axis_high;
    logic                    saturated;
    int                      mismatches;
    int                      pending;
    int                      stall_run = 0;
    int                      stall_mode = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    aabb_accumulate_transform_test_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_opcode    (opcode),
        .i_lo_x      (lo_x),
        .i_lo_y      (lo_y),
        .i_lo_z      (lo_z),
        .i_hi_x      (hi_x),
        .i_hi_y      (hi_y),
        .i_hi_z      (hi_z),
        .i_axis      (axis),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_box_min_x (box_min_x),
        .o_box_min_y (box_min_y),
        .o_box_min_z (box_min_z),
        .o_box_max_x (box_max_x),
        .o_box_max_y (box_max_y),
        .o_box_max_z (box_max_z),
        .o_overlap   (overlap),
        .o_axis_low  (axis_low),
        .o_axis_high (axis_high),
        .o_saturated (saturated)
    );

    aabb_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_opcode     (opcode),
        .i_lo_x       (lo_x),
        .i_lo_y       (lo_y),
        .i_lo_z       (lo_z),
        .i_hi_x       (hi_x),
        .i_hi_y       (hi_y),
        .i_hi_z       (hi_z),
        .i_axis       (axis),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_box_min_x  (box_min_x),
        .i_box_min_y  (box_min_y),
        .i_box_min_z  (box_min_z),
        .i_box_max_x  (box_max_x),
        .i_box_max_y  (box_max_y),
        .i_box_max_z  (box_max_z),
        .i_overlap    (overlap),
        .i_axis_low   (axis_low),
        .i_axis_high  (axis_high),
        .i_saturated  (saturated),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // receiver backpressure: runs of no stall, light, heavy and periodic stall
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_run  <= $urandom_range(8, 60);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= stall_run[2];
        endcase
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    function automatic logic signed [W-1:0] corner_value();
        case ($urandom_range(0, 4))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return '0;
            3:       return -1;
            default: return ONE;
        endcase
    endfunction

    // mostly small Q16.16 values in +/- span, with full-range and edge values
    function automatic logic signed [W-1:0] rand_fixed(input int span);
        int v;
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return corner_value();
            default: begin
                v = int'($urandom_range(0, 2 * span)) - span;
                return v;
            end
        endcase
    endfunction

    task automatic send_beat(
        input logic [OPCODE_WIDTH-1:0] op,
        input logic signed [W-1:0] lx, input logic signed [W-1:0] ly,
        input logic signed [W-1:0] lz, input logic signed [W-1:0] hx,
        input logic signed [W-1:0] hy, input logic signed [W-1:0] hz,
        input logic [AXIS_WIDTH-1:0] ax
    );
        @(negedge i_clk);
        in_valid = 1'b1;
        opcode   = op;
        lo_x     = lx;
        lo_y     = ly;
        lo_z     = lz;
        hi_x     = hx;
        hi_y     = hy;
        hi_z     = hz;
        axis     = ax;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            in_valid = 1'b0;
            opcode   = OPCODE_WIDTH'($urandom);
            lo_x     = $urandom;
            hi_z     = $urandom;
        end
    endtask

    initial begin
        int                      burst_left;
        int                      pick;
        logic [OPCODE_WIDTH-1:0] op;
        logic signed [W-1:0]     lx, ly, lz, hx, hy, hz;
        logic [AXIS_WIDTH-1:0]   ax;

        burst_left = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        rst_n = 1'b1;

        // empty box as it comes out of reset
        send_beat(OP_TRANSFORM, ONE, ONE, ONE, '0, '0, '0, 2'd0);
        send_beat(OP_OVERLAP, -ONE, -ONE, -ONE, ONE, ONE, ONE, 2'd1);
        send_beat(OP_TRANSFORM, '0, '0, '0, 5 * ONE, '0, '0, 2'd2);
        // small box, signed and fractional coefficients
        send_beat(OP_ADD_POINT, ONE, 2 * ONE, -3 * ONE, '0, '0, '0, 2'd0);
        send_beat(OP_ADD_POINT, -ONE / 2, 4 * ONE, '0, C_MAX, C_MIN, '0, 2'd3);
        send_beat(OP_MERGE_BOX, '0, '0, -8 * ONE, 10 * ONE, ONE, ONE, 2'd0);
        send_beat(OP_TRANSFORM, 2 * ONE, -ONE, ONE / 2, ONE, '0, '0, 2'd0);
        send_beat(OP_TRANSFORM, -ONE, 3 * ONE, -2 * ONE, -7 * ONE, '0, '0, 2'd1);
        send_beat(OP_TRANSFORM, 1, -1, 3, '0, '0, '0, 2'd2);
        send_beat(OP_TRANSFORM, ONE, ONE, ONE, ONE, '0, '0, AXIS_NONE);
        // inclusive touch on every axis, then one lsb past it
        send_beat(OP_OVERLAP, 10 * ONE, 4 * ONE, ONE, 20 * ONE, 9 * ONE, 9 * ONE, 2'd0);
        send_beat(OP_OVERLAP, 10 * ONE + 1, 4 * ONE, ONE, 20 * ONE, 9 * ONE, 9 * ONE,
                  2'd0);
        for (int code = OP_UNUSED_FIRST; code <= OP_UNUSED_LAST; code++)
            send_beat(OPCODE_WIDTH'(code), $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, AXIS_WIDTH'($urandom));
        send_beat(OP_TRANSFORM, C_MIN, C_MAX, C_MIN, C_MAX, '0, '0, 2'd0);
        // full-range box
        send_beat(OP_ADD_POINT, C_MIN, C_MAX, C_MIN, '0, '0, '0, 2'd1);
        send_beat(OP_ADD_POINT, C_MAX, C_MIN, C_MAX, '0, '0, '0, 2'd2);
        send_beat(OP_TRANSFORM, -ONE, ONE, -ONE, C_MIN, '0, '0, 2'd1);
        send_beat(OP_OVERLAP, '0, '0, '0, '0, '0, '0, 2'd0);
        // inverted box from a merge with min above max
        send_beat(OP_RESET, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, 2'd0);
        send_beat(OP_MERGE_BOX, 5 * ONE, 5 * ONE, 5 * ONE, -5 * ONE, -5 * ONE,
                  -5 * ONE, 2'd0);
        send_beat(OP_OVERLAP, -ONE, -ONE, -ONE, ONE, ONE, ONE, 2'd0);
        send_beat(OP_TRANSFORM, ONE, -ONE, 2 * ONE, ONE, '0, '0, 2'd2);
        // empty box against the whole range
        send_beat(OP_RESET, '0, '0, '0, '0, '0, '0, 2'd0);
        send_beat(OP_OVERLAP, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 2'd0);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            pick = $urandom_range(0, 99);
            if (pick < 4)       op = OP_RESET;
            else if (pick < 34) op = OP_ADD_POINT;
            else if (pick < 52) op = OP_MERGE_BOX;
            else if (pick < 77) op = OP_TRANSFORM;
            else if (pick < 94) op = OP_OVERLAP;
            else op = OPCODE_WIDTH'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
            if (op == OP_TRANSFORM) begin
                lx = rand_fixed(4 * ONE);
                ly = rand_fixed(4 * ONE);
                lz = rand_fixed(4 * ONE);
                ax = ($urandom_range(0, 9) == 0) ? AXIS_NONE
                                                 : AXIS_WIDTH'($urandom_range(0, 2));
            end else begin
                lx = rand_fixed(64 * ONE);
                ly = rand_fixed(64 * ONE);
                lz = rand_fixed(64 * ONE);
                ax = AXIS_WIDTH'($urandom);
            end
            // other boxes are mostly well formed, sometimes arbitrary
            if ($urandom_range(0, 7) == 0) begin
                hx = rand_fixed(64 * ONE);
                hy = rand_fixed(64 * ONE);
                hz = rand_fixed(64 * ONE);
            end else begin
                hx = lx + $urandom_range(0, 32 * ONE);
                hy = ly + $urandom_range(0, 32 * ONE);
                hz = lz + $urandom_range(0, 32 * ONE);
            end
            if (op == OP_TRANSFORM) hx = rand_fixed(64 * ONE);
            send_beat(op, lx, ly, lz, hx, hy, hz, ax);
        end

        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
